@@ src/ssc_pkg.sv @@
// ssc_pkg: shared types, constants and helper functions for the six-step
// commutation block with pi speed loop. no dependencies.
`timescale 1ns / 1ps

package ssc_pkg;

    // angle resolution: 2^ANGLE_BITS is one electrical turn
    localparam int ANGLE_BITS  = 16;
    localparam int SECTOR_BITS = 3;

    // field widths
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 32;
    localparam int PERIOD_W = 16;
    localparam int SPEED_W  = 16;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DUTY_W   = 17;
    localparam int ACC_W    = 34;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: 25 x 18 signed, registered 43-bit product
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // accumulator halves fed through the multiplier
    localparam int ACC_LO_W = 17;
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;

    localparam logic [DUTY_W-1:0] DUTY_ONE  = DUTY_W'(65536);
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(32768);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEG_GAIN    = 2'd1,
        CFG_INTEG_LIMIT   = 2'd2,
        CFG_SAMPLE_PERIOD = 2'd3
    } cfg_reg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM_I,
        ST_LEVEL
    } state_t;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_ERR_SP,
        MUL_KP_ERR,
        MUL_KI_LO,
        MUL_KI_HI
    } mul_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     acc_upd;
        logic     p_load;
        logic     lo_load;
        logic     i_load;
        logic     out_load;
    } cmd_t;

    // phase drive direction
    typedef enum logic [1:0] {
        DIR_FLOAT,
        DIR_HIGH,
        DIR_LOW
    } dir_t;

    // 120-degree pattern: direction of each phase (a, b, c) per sector
    function automatic dir_t sector_dir(input logic [SECTOR_BITS-1:0] sector,
                                        input logic [1:0] phase);
        dir_t d;
        d = DIR_FLOAT;
        case (sector)
            3'd0: d = (phase == 2'd0) ? DIR_HIGH : (phase == 2'd1) ? DIR_LOW : DIR_FLOAT;
            3'd1: d = (phase == 2'd0) ? DIR_HIGH : (phase == 2'd1) ? DIR_FLOAT : DIR_LOW;
            3'd2: d = (phase == 2'd0) ? DIR_FLOAT : (phase == 2'd1) ? DIR_HIGH : DIR_LOW;
            3'd3: d = (phase == 2'd0) ? DIR_LOW : (phase == 2'd1) ? DIR_HIGH : DIR_FLOAT;
            3'd4: d = (phase == 2'd0) ? DIR_LOW : (phase == 2'd1) ? DIR_FLOAT : DIR_HIGH;
            3'd5: d = (phase == 2'd0) ? DIR_FLOAT : (phase == 2'd1) ? DIR_LOW : DIR_HIGH;
            default: d = DIR_FLOAT;
        endcase
        return d;
    endfunction

    // phase duty from direction; zero duty floats every phase
    function automatic logic [DUTY_W-1:0] phase_value(input dir_t d,
                                                      input logic [DUTY_W-1:0] duty);
        logic [DUTY_W-1:0] v;
        v = DUTY_HALF;
        if (duty != '0) begin
            case (d)
                DIR_HIGH: v = duty;
                DIR_LOW:  v = '0;
                default:  v = DUTY_HALF;
            endcase
        end
        return v;
    endfunction

endpackage

@@ src/ssc_ctrl.sv @@
// ssc_ctrl: sequencing state machine for the pi update and result hand-off.
// depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_ctrl
    import ssc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;

    // output register still holds a beat that is not taken this cycle
    assign out_busy = out_valid_reg & ~m_ready;

    // state and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_ERR_SP;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL_ERR;
                end
            end
            ST_MUL_ERR: begin
                cmd.mul_sel = MUL_ERR_SP;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_upd = 1'b1;
                cmd.mul_sel = MUL_KP_ERR;
                state_next  = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.p_load  = 1'b1;
                cmd.mul_sel = MUL_KI_LO;
                state_next  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.lo_load = 1'b1;
                cmd.mul_sel = MUL_KI_HI;
                state_next  = ST_SUM_I;
            end
            ST_SUM_I: begin
                cmd.i_load = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (!out_busy) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

@@ src/ssc_datapath.sv @@
// ssc_datapath: shared multiplier, integral accumulator, duty saturation,
// sector decode and result registers. depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_datapath
    import ssc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cmd_t                         cmd,
    input  logic [GAIN_W-1:0]            prop_gain,
    input  logic [GAIN_W-1:0]            integ_gain,
    input  logic [LIMIT_W-1:0]           integ_limit,
    input  logic [PERIOD_W-1:0]          sample_period,
    input  logic [ANGLE_BITS-1:0]        s_elec_angle,
    input  logic signed [SPEED_W-1:0]    s_speed_target,
    input  logic signed [SPEED_W-1:0]    s_speed_measured,
    output logic [DUTY_W-1:0]            m_phase_a_duty,
    output logic [DUTY_W-1:0]            m_phase_b_duty,
    output logic [DUTY_W-1:0]            m_phase_c_duty,
    output logic [DUTY_W-1:0]            m_drive_level,
    output logic [SECTOR_BITS-1:0]       m_sector_index
);

    localparam int SUM_W   = ACC_W + 1;
    localparam int FULL_W  = 59;
    localparam int P_W     = 42;
    localparam int I_W     = FULL_W - 16;
    localparam int LEVEL_W = 44;
    localparam int SECT_W  = ANGLE_BITS + 3;

    logic signed [ERR_W-1:0]      error_reg;
    logic [SECTOR_BITS-1:0]       sector_reg;
    logic signed [ACC_W-1:0]      accum_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [P_W-1:0]        p_reg;
    logic [P_W-1:0]               lo_reg;
    logic signed [I_W-1:0]        i_reg;

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [SUM_W-1:0]      acc_sum;
    logic signed [SUM_W-1:0]      lim_pos;
    logic signed [SUM_W-1:0]      lim_neg;
    logic signed [SUM_W-1:0]      acc_clamp;
    logic signed [FULL_W-1:0]     full_i;
    logic signed [LEVEL_W-1:0]    level_sum;
    logic [DUTY_W-1:0]            duty;
    logic [SECT_W-1:0]            angle_x6;

    // sector = floor(angle * 6 / 2^ANGLE_BITS), as shift-add
    assign angle_x6 = {1'b0, s_elec_angle, 2'b00} + {2'b00, s_elec_angle, 1'b0};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_ERR_SP: begin
                mul_a = $signed({{(MUL_A_W-PERIOD_W){1'b0}}, sample_period});
                mul_b = $signed({error_reg[ERR_W-1], error_reg});
            end
            MUL_KP_ERR: begin
                mul_a = $signed({1'b0, prop_gain});
                mul_b = $signed({error_reg[ERR_W-1], error_reg});
            end
            MUL_KI_LO: begin
                mul_a = $signed({1'b0, integ_gain});
                mul_b = $signed({1'b0, accum_reg[ACC_LO_W-1:0]});
            end
            MUL_KI_HI: begin
                mul_a = $signed({1'b0, integ_gain});
                mul_b = $signed({accum_reg[ACC_W-1], accum_reg[ACC_W-1:ACC_LO_W]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // integral update from the registered error * period product, then clamp
    assign acc_sum = $signed({accum_reg[ACC_W-1], accum_reg})
                   + $signed({{(SUM_W-33){prod_reg[32]}}, prod_reg[32:0]});
    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, integ_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        acc_clamp = acc_sum;
        if (acc_sum > lim_pos) begin
            acc_clamp = lim_pos;
        end else if (acc_sum < lim_neg) begin
            acc_clamp = lim_neg;
        end
    end

    // ki * accum from its two partial products, floored by 2^16
    assign full_i = $signed({prod_reg[P_W-1:0], {ACC_LO_W{1'b0}}})
                  + $signed({{(FULL_W-P_W){1'b0}}, lo_reg});

    // drive level and saturation to [0, 1.0]
    assign level_sum = $signed({{(LEVEL_W-P_W){p_reg[P_W-1]}}, p_reg})
                     + $signed({{(LEVEL_W-I_W){i_reg[I_W-1]}}, i_reg});

    always_comb begin
        if (level_sum[LEVEL_W-1]) begin
            duty = '0;
        end else if (level_sum > $signed(LEVEL_W'(DUTY_ONE))) begin
            duty = DUTY_ONE;
        end else begin
            duty = level_sum[DUTY_W-1:0];
        end
    end

    // integral accumulator, the only state kept between items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
        end else if (cmd.acc_upd) begin
            accum_reg <= acc_clamp[ACC_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.capture) begin
            error_reg  <= $signed({s_speed_target[SPEED_W-1], s_speed_target})
                        - $signed({s_speed_measured[SPEED_W-1], s_speed_measured});
            sector_reg <= angle_x6[SECT_W-1:ANGLE_BITS];
        end
        if (cmd.p_load) begin
            p_reg <= prod_reg[P_W-1:0];
        end
        if (cmd.lo_load) begin
            lo_reg <= prod_reg[P_W-1:0];
        end
        if (cmd.i_load) begin
            i_reg <= full_i[FULL_W-1:16];
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_phase_a_duty <= phase_value(sector_dir(sector_reg, 2'd0), duty);
            m_phase_b_duty <= phase_value(sector_dir(sector_reg, 2'd1), duty);
            m_phase_c_duty <= phase_value(sector_dir(sector_reg, 2'd2), duty);
            m_drive_level  <= duty;
            m_sector_index <= sector_reg;
        end
    end

endmodule

@@ src/six_step_commutation_pi_speed_unit.sv @@
// six_step_commutation_pi_speed_unit: top level with the configuration
// registers. depends on ssc_pkg, ssc_ctrl and ssc_datapath.
`timescale 1ns / 1ps

// usage:
// - configuration: write prop_gain (0), integ_gain (1), integ_limit (2) and
//   sample_period (3) over the cfg channel while no item is in flight;
//   cfg_ready is always high and a beat takes effect at once
// - input channel s_*: electrical angle plus reference and measured speed;
//   each beat gives exactly one result beat on m_*
// - one item is worked on at a time: a new input beat is taken only after the
//   last one has reached the output register, set by the four passes through
//   the one shared 25x18 multiplier plus the add stages
// - the result sits in an output register; the next item is accepted while
//   it waits, and its last step holds until the old result is taken
// - m_ready low simply holds m_valid and the result fields
// - reset (aresetn low, synchronous) clears the integral, all gains, the
//   limit and the sample period to zero and drops any pending result
module six_step_commutation_pi_speed_unit
    import ssc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ANGLE_BITS-1:0]     s_elec_angle,
    input  logic signed [SPEED_W-1:0] s_speed_target,
    input  logic signed [SPEED_W-1:0] s_speed_measured,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DUTY_W-1:0]         m_phase_a_duty,
    output logic [DUTY_W-1:0]         m_phase_b_duty,
    output logic [DUTY_W-1:0]         m_phase_c_duty,
    output logic [DUTY_W-1:0]         m_drive_level,
    output logic [SECTOR_BITS-1:0]    m_sector_index
);

    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   integ_gain_reg;
    logic [LIMIT_W-1:0]  integ_limit_reg;
    logic [PERIOD_W-1:0] sample_period_reg;
    cmd_t                cmd;

    assign cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            integ_limit_reg   <= '0;
            sample_period_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT:   integ_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    ssc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // arithmetic and result registers
    ssc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .prop_gain        (prop_gain_reg),
        .integ_gain       (integ_gain_reg),
        .integ_limit      (integ_limit_reg),
        .sample_period    (sample_period_reg),
        .s_elec_angle     (s_elec_angle),
        .s_speed_target   (s_speed_target),
        .s_speed_measured (s_speed_measured),
        .m_phase_a_duty   (m_phase_a_duty),
        .m_phase_b_duty   (m_phase_b_duty),
        .m_phase_c_duty   (m_phase_c_duty),
        .m_drive_level    (m_drive_level),
        .m_sector_index   (m_sector_index)
    );

endmodule

@@ tb/sv/six_step_commutation_pi_speed_unit_test.sv @@
// six_step_commutation_pi_speed_unit_test: self-checking bench for the six-step
// commutation block with pi speed loop; a tracker class predicts every beat.
// depends on ssc_pkg and six_step_commutation_pi_speed_unit.
`timescale 1ns / 1ps

module six_step_commutation_pi_speed_unit_test;
    import ssc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 205;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 20;

    // one result beat
    typedef struct packed {
        logic [DUTY_W-1:0]      phase_a;
        logic [DUTY_W-1:0]      phase_b;
        logic [DUTY_W-1:0]      phase_c;
        logic [DUTY_W-1:0]      level;
        logic [SECTOR_BITS-1:0] sector;
    } drive_beat_t;

    // predicts the pi loop and commutation, holds the drives still owed
    class drive_tracker;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [LIMIT_W-1:0]  limit;
        logic [PERIOD_W-1:0] period;
        longint              integ;
        drive_beat_t         expected_drives[$];
        int                  mismatches;
        int                  inputs_seen;
        int                  results_seen;

        function new();
            kp = '0;
            ki = '0;
            limit = '0;
            period = '0;
            integ = 0;
            mismatches = 0;
            inputs_seen = 0;
            results_seen = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PROP_GAIN:     kp = data[GAIN_W-1:0];
                CFG_INTEG_GAIN:    ki = data[GAIN_W-1:0];
                CFG_INTEG_LIMIT:   limit = data[LIMIT_W-1:0];
                CFG_SAMPLE_PERIOD: period = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // high-side and low-side phase per sector, the third one floats
        function logic [DUTY_W-1:0] phase_drive(logic [SECTOR_BITS-1:0] sec, int ph,
                                                logic [DUTY_W-1:0] duty);
            int hi_ph;
            int lo_ph;
            case (sec)
                3'd0: begin hi_ph = 0; lo_ph = 1; end
                3'd1: begin hi_ph = 0; lo_ph = 2; end
                3'd2: begin hi_ph = 1; lo_ph = 2; end
                3'd3: begin hi_ph = 1; lo_ph = 0; end
                3'd4: begin hi_ph = 2; lo_ph = 0; end
                default: begin hi_ph = 2; lo_ph = 1; end
            endcase
            // zero duty floats everything
            if (duty == '0 || (ph != hi_ph && ph != lo_ph))
                return DUTY_HALF;
            return (ph == hi_ph) ? duty : '0;
        endfunction

        function void note_sample(logic [ANGLE_BITS-1:0] angle,
                                  logic signed [SPEED_W-1:0] tgt,
                                  logic signed [SPEED_W-1:0] meas);
            longint      err;
            longint      acc;
            longint      level;
            drive_beat_t d;
            err = longint'(tgt) - longint'(meas);
            // integral with symmetric clamp
            acc = integ + err * longint'(period);
            if (acc > longint'(limit))
                acc = longint'(limit);
            if (acc < -longint'(limit))
                acc = -longint'(limit);
            integ = acc;
            // p + i, i floored to q.16, then saturated
            level = longint'(kp) * err + ((longint'(ki) * integ) >>> 16);
            if (level < 0)
                level = 0;
            if (level > 65536)
                level = 65536;
            d.level = DUTY_W'(level);
            d.sector = SECTOR_BITS'((32'(angle) * 32'd6) >> ANGLE_BITS);
            d.phase_a = phase_drive(d.sector, 0, d.level);
            d.phase_b = phase_drive(d.sector, 1, d.level);
            d.phase_c = phase_drive(d.sector, 2, d.level);
            expected_drives.push_back(d);
            inputs_seen++;
        endfunction

        function void check_drive(drive_beat_t got);
            drive_beat_t exp_d;
            results_seen++;
            if (expected_drives.size() == 0) begin
                $error("result beat with no input beat pending");
                mismatches++;
                return;
            end
            exp_d = expected_drives.pop_front();
            if (got.phase_a !== exp_d.phase_a) begin
                $error("phase_a_duty: expected %0d, actual %0d", exp_d.phase_a, got.phase_a);
                mismatches++;
            end
            if (got.phase_b !== exp_d.phase_b) begin
                $error("phase_b_duty: expected %0d, actual %0d", exp_d.phase_b, got.phase_b);
                mismatches++;
            end
            if (got.phase_c !== exp_d.phase_c) begin
                $error("phase_c_duty: expected %0d, actual %0d", exp_d.phase_c, got.phase_c);
                mismatches++;
            end
            if (got.level !== exp_d.level) begin
                $error("drive_level: expected %0d, actual %0d", exp_d.level, got.level);
                mismatches++;
            end
            if (got.sector !== exp_d.sector) begin
                $error("sector_index: expected %0d, actual %0d", exp_d.sector, got.sector);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [ANGLE_BITS-1:0]     s_elec_angle;
    logic signed [SPEED_W-1:0] s_speed_target;
    logic signed [SPEED_W-1:0] s_speed_measured;
    logic                      m_valid;
    logic                      m_ready;
    logic [DUTY_W-1:0]         m_phase_a_duty;
    logic [DUTY_W-1:0]         m_phase_b_duty;
    logic [DUTY_W-1:0]         m_phase_c_duty;
    logic [DUTY_W-1:0]         m_drive_level;
    logic [SECTOR_BITS-1:0]    m_sector_index;

    drive_tracker tracker = new();
    bit           flat_mode = 1'b0;
    int           sink_hold = 0;
    int           settings_used = 0;
    int           idle_cycles = 0;

    six_step_commutation_pi_speed_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elec_angle     (s_elec_angle),
        .s_speed_target   (s_speed_target),
        .s_speed_measured (s_speed_measured),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_phase_a_duty   (m_phase_a_duty),
        .m_phase_b_duty   (m_phase_b_duty),
        .m_phase_c_duty   (m_phase_c_duty),
        .m_drive_level    (m_drive_level),
        .m_sector_index   (m_sector_index)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // watchdog: cycles without any beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no beat for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one register beat; valid stays up for back-to-back writes
    task automatic write_beat(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                logic [LIMIT_W-1:0] lim, logic [PERIOD_W-1:0] sp);
        write_beat(CFG_PROP_GAIN, CFG_DATA_W'(kp));
        write_beat(CFG_INTEG_GAIN, CFG_DATA_W'(ki));
        write_beat(CFG_INTEG_LIMIT, CFG_DATA_W'(lim));
        write_beat(CFG_SAMPLE_PERIOD, CFG_DATA_W'(sp));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // input beat with a random gap ahead of it
    task automatic send_sample(logic [ANGLE_BITS-1:0] angle,
                               logic signed [SPEED_W-1:0] tgt,
                               logic signed [SPEED_W-1:0] meas);
        int gap;
        gap = flat_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elec_angle <= angle;
        s_speed_target <= tgt;
        s_speed_measured <= meas;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.note_sample(angle, tgt, meas);
    endtask

    // mostly small errors so the duty lands inside its range
    task automatic send_random();
        logic [ANGLE_BITS-1:0]     angle;
        logic signed [SPEED_W-1:0] tgt;
        logic signed [SPEED_W-1:0] meas;
        angle = ANGLE_BITS'($urandom);
        tgt = SPEED_W'($urandom);
        case ($urandom_range(0, 3))
            0, 1: meas = tgt - SPEED_W'($urandom_range(0, 600)) + SPEED_W'(300);
            2: meas = SPEED_W'($urandom);
            default: begin
                tgt = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                meas = $urandom_range(0, 1) ? tgt : SPEED_W'($urandom);
            end
        endcase
        send_sample(angle, tgt, meas);
    endtask

    task automatic drain();
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                             logic [LIMIT_W-1:0] lim, logic [PERIOD_W-1:0] sp);
        drain();
        program_regs(kp, ki, lim, sp);
        repeat (PHASE_ITEMS) send_random();
        s_valid <= 1'b0;
    endtask

    // result side: random ready gaps, or one long hold when asked
    task automatic sink_results();
        int          w;
        drive_beat_t got;
        forever begin
            if (sink_hold > 0) begin
                w = sink_hold;
                sink_hold = 0;
            end else begin
                w = flat_mode ? 0 : $urandom_range(0, 3);
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            got.phase_a = m_phase_a_duty;
            got.phase_b = m_phase_b_duty;
            got.phase_c = m_phase_c_duty;
            got.level = m_drive_level;
            got.sector = m_sector_index;
            tracker.check_drive(got);
        end
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PROP_GAIN;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_elec_angle <= '0;
        s_speed_target <= '0;
        s_speed_measured <= '0;
        m_ready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            sink_results();
        join_none

        // reset gains: duty stays zero so every phase floats
        send_sample(16'd5000, 16'sd1000, -16'sd1000);
        send_sample(16'd40000, 16'sh7fff, 16'sh8000);
        s_valid <= 1'b0;

        // p only, zero limit holds the integral at zero
        drain();
        program_regs(24'd1, 24'd65536, 32'd0, 16'hffff);
        // sector boundaries
        send_sample(16'd0, 16'sd1000, 16'sd0);
        send_sample(16'd10922, 16'sd1000, 16'sd0);
        send_sample(16'd10923, 16'sd1000, 16'sd0);
        send_sample(16'd21845, 16'sd1000, 16'sd0);
        send_sample(16'd21846, 16'sd1000, 16'sd0);
        send_sample(16'd32767, 16'sd1000, 16'sd0);
        send_sample(16'd32768, 16'sd1000, 16'sd0);
        send_sample(16'd43690, 16'sd1000, 16'sd0);
        send_sample(16'd43691, 16'sd1000, 16'sd0);
        send_sample(16'd54613, 16'sd1000, 16'sd0);
        send_sample(16'd54614, 16'sd1000, 16'sd0);
        send_sample(16'hffff, 16'sd1000, 16'sd0);
        // speed extremes, zero and negative error give zero duty
        send_sample(16'd3000, 16'sh7fff, 16'sh8000);
        send_sample(16'd25000, 16'sh8000, 16'sh7fff);
        send_sample(16'd50000, 16'sd0, 16'sd0);
        send_sample(16'd60000, 16'sd1, 16'sd0);
        send_sample(16'd15000, 16'sh7fff, 16'sh7fff);
        send_sample(16'd35000, 16'sh8000, 16'sh8000);
        s_valid <= 1'b0;

        // random phases across gain and limit settings
        run_phase(24'd1, 24'd0, 32'd0, 16'd0);
        run_phase(24'd0, 24'd65536, 32'd60000, 16'hffff);
        run_phase(24'hffffff, 24'hffffff, 32'hffffffff, 16'hffff);
        run_phase(GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 131072)),
                  LIMIT_W'($urandom_range(0, 1048576)), PERIOD_W'($urandom));
        run_phase(GAIN_W'($urandom), GAIN_W'($urandom), LIMIT_W'($urandom),
                  PERIOD_W'($urandom));
        run_phase(24'd65536, 24'd1, 32'd1, 16'd1);

        // no idling, and a long result hold that backs up the input
        drain();
        flat_mode = 1'b1;
        sink_hold = HOLD_CYCLES;
        run_phase(24'd3, 24'd1000, 32'h01000000, 16'd100);
        drain();
        flat_mode = 1'b0;

        run_phase(GAIN_W'($urandom_range(0, 2048)), GAIN_W'($urandom_range(0, 1 << 20)),
                  LIMIT_W'($urandom), PERIOD_W'($urandom_range(0, 4096)));

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("%0d expected result beats never arrived", tracker.pending());
            tracker.mismatches++;
        end
        $display("drove %0d input beats and checked %0d result beats",
                 tracker.inputs_seen, tracker.results_seen);
        $display("over %0d register settings, including a %0d-cycle output hold",
                 settings_used, HOLD_CYCLES);
        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ six_step_commutation_pi_speed_unit.f @@
src/ssc_pkg.sv
src/ssc_ctrl.sv
src/ssc_datapath.sv
src/six_step_commutation_pi_speed_unit.sv
tb/sv/six_step_commutation_pi_speed_unit_test.sv
